[rtl/sgi_pkg.sv]
package sgi_pkg;

    localparam int COORD_W  = 20;
    localparam int TOL_W    = 8;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int KPROD_W  = 2 * COORD_W;
    localparam int K_W      = 2 * COORD_W + 1;
    localparam int PP_W     = 2 * DIFF_W;
    localparam int DEN_W    = 2 * COORD_W + 3;
    localparam int NUM_W    = 3 * COORD_W + 3;
    localparam int QB       = COORD_W + 2;   // quotient bits below the overflow limit
    localparam int OVF_W    = DEN_W + QB;
    localparam int CMP_W    = COORD_W + 4;
    localparam int FRONT_STAGES = 8;
    localparam int TOL_RESET    = 1;

    localparam logic signed [CMP_W-1:0] CMAX_C = CMP_W'((64'd1 << (COORD_W - 1)) - 64'd1);
    localparam logic signed [CMP_W-1:0] CMIN_C = -CMAX_C - CMP_W'(1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t point_a_x;
        coord_t point_a_y;
        coord_t point_b_x;
        coord_t point_b_y;
        coord_t point_c_x;
        coord_t point_c_y;
        coord_t point_d_x;
        coord_t point_d_y;
    } seg_in_t;

    typedef struct packed {
        logic   segments_hit;
        logic   lines_parallel;
        coord_t cross_x;
        coord_t cross_y;
        logic   point_saturated;
    } seg_out_t;

    // one lane of the divider chain
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QB-1:0]    num;
        logic [DEN_W-1:0] dm;
        logic [QB-1:0]    q;
        logic             neg;
        logic             ovf;
        logic             zero;
    } div_t;

    // bounding boxes, carried alongside the arithmetic
    typedef struct packed {
        logic   overlap;
        coord_t l1;
        coord_t r1;
        coord_t t1;
        coord_t b1;
        coord_t l2;
        coord_t r2;
        coord_t t2;
        coord_t b2;
    } side_t;

endpackage

[rtl/sgi_front.sv]
module sgi_front (
    input  logic            clk,
    input  logic            en,
    input  sgi_pkg::seg_in_t seg,
    output sgi_pkg::div_t   div_x,
    output sgi_pkg::div_t   div_y
);
    import sgi_pkg::*;

    // stage 1: direction differences
    seg_in_t                   pt_reg;
    logic signed [DIFF_W-1:0]  abx_reg, aby_reg, cdx_reg, cdy_reg;
    // stage 2: products
    logic signed [PP_W-1:0]    pd1_reg, pd2_reg;
    logic signed [KPROD_W-1:0] pk1_reg, pk2_reg, pk3_reg, pk4_reg;
    logic signed [DIFF_W-1:0]  abx2_reg, aby2_reg, cdx2_reg, cdy2_reg;
    // stage 3: determinant and line constants
    logic signed [DEN_W-1:0]   den3_reg;
    logic signed [K_W-1:0]     k1_reg, k2_reg;
    logic signed [DIFF_W-1:0]  abx3_reg, aby3_reg, cdx3_reg, cdy3_reg;
    // stage 4: partial products, k split at COORD_W
    logic signed [PP_W-1:0]    m1xl_reg, m1xh_reg, m1yl_reg, m1yh_reg;
    logic signed [PP_W-1:0]    m2xl_reg, m2xh_reg, m2yl_reg, m2yh_reg;
    logic signed [DEN_W-1:0]   den4_reg;
    // stage 5: full products
    logic signed [NUM_W-1:0]   kx1_reg, kx2_reg, ky1_reg, ky2_reg;
    logic signed [DEN_W-1:0]   den5_reg;
    // stage 6: numerators
    logic signed [NUM_W-1:0]   nx_reg, ny_reg;
    logic signed [DEN_W-1:0]   den6_reg;
    // stage 7: magnitudes
    logic [NUM_W-1:0]          nmx_reg, nmy_reg;
    logic [DEN_W-1:0]          dm_reg;
    logic                      negx_reg, negy_reg, zero_reg;
    // stage 8
    div_t                      dx_reg, dy_reg;

    logic signed [DIFF_W-1:0] k1lo, k1hi, k2lo, k2hi;

    always_comb
    begin
        k1lo = $signed({1'b0, k1_reg[COORD_W-1:0]});
        k1hi = $signed(k1_reg[K_W-1:COORD_W]);
        k2lo = $signed({1'b0, k2_reg[COORD_W-1:0]});
        k2hi = $signed(k2_reg[K_W-1:COORD_W]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg  <= seg;
            abx_reg <= DIFF_W'(seg.point_a_x) - DIFF_W'(seg.point_b_x);
            aby_reg <= DIFF_W'(seg.point_a_y) - DIFF_W'(seg.point_b_y);
            cdx_reg <= DIFF_W'(seg.point_c_x) - DIFF_W'(seg.point_d_x);
            cdy_reg <= DIFF_W'(seg.point_c_y) - DIFF_W'(seg.point_d_y);

            pd1_reg  <= abx_reg * cdy_reg;
            pd2_reg  <= aby_reg * cdx_reg;
            pk1_reg  <= pt_reg.point_a_x * pt_reg.point_b_y;
            pk2_reg  <= pt_reg.point_a_y * pt_reg.point_b_x;
            pk3_reg  <= pt_reg.point_c_x * pt_reg.point_d_y;
            pk4_reg  <= pt_reg.point_c_y * pt_reg.point_d_x;
            abx2_reg <= abx_reg;
            aby2_reg <= aby_reg;
            cdx2_reg <= cdx_reg;
            cdy2_reg <= cdy_reg;

            den3_reg <= DEN_W'(pd1_reg) - DEN_W'(pd2_reg);
            k1_reg   <= K_W'(pk1_reg) - K_W'(pk2_reg);
            k2_reg   <= K_W'(pk3_reg) - K_W'(pk4_reg);
            abx3_reg <= abx2_reg;
            aby3_reg <= aby2_reg;
            cdx3_reg <= cdx2_reg;
            cdy3_reg <= cdy2_reg;

            m1xl_reg <= k1lo * cdx3_reg;
            m1xh_reg <= k1hi * cdx3_reg;
            m1yl_reg <= k1lo * cdy3_reg;
            m1yh_reg <= k1hi * cdy3_reg;
            m2xl_reg <= k2lo * abx3_reg;
            m2xh_reg <= k2hi * abx3_reg;
            m2yl_reg <= k2lo * aby3_reg;
            m2yh_reg <= k2hi * aby3_reg;
            den4_reg <= den3_reg;

            kx1_reg  <= (NUM_W'(m1xh_reg) <<< COORD_W) + NUM_W'(m1xl_reg);
            ky1_reg  <= (NUM_W'(m1yh_reg) <<< COORD_W) + NUM_W'(m1yl_reg);
            kx2_reg  <= (NUM_W'(m2xh_reg) <<< COORD_W) + NUM_W'(m2xl_reg);
            ky2_reg  <= (NUM_W'(m2yh_reg) <<< COORD_W) + NUM_W'(m2yl_reg);
            den5_reg <= den4_reg;

            nx_reg   <= kx1_reg - kx2_reg;
            ny_reg   <= ky1_reg - ky2_reg;
            den6_reg <= den5_reg;

            nmx_reg  <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            nmy_reg  <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            dm_reg   <= den6_reg[DEN_W-1] ? DEN_W'(-den6_reg) : DEN_W'(den6_reg);
            negx_reg <= nx_reg[NUM_W-1] ^ den6_reg[DEN_W-1];
            negy_reg <= ny_reg[NUM_W-1] ^ den6_reg[DEN_W-1];
            zero_reg <= (den6_reg == '0);

            dx_reg.rem  <= DEN_W'(nmx_reg >> QB);
            dx_reg.num  <= nmx_reg[QB-1:0];
            dx_reg.dm   <= dm_reg;
            dx_reg.q    <= '0;
            dx_reg.neg  <= negx_reg;
            dx_reg.ovf  <= OVF_W'(nmx_reg) >= {dm_reg, QB'(0)};
            dx_reg.zero <= zero_reg;
            dy_reg.rem  <= DEN_W'(nmy_reg >> QB);
            dy_reg.num  <= nmy_reg[QB-1:0];
            dy_reg.dm   <= dm_reg;
            dy_reg.q    <= '0;
            dy_reg.neg  <= negy_reg;
            dy_reg.ovf  <= OVF_W'(nmy_reg) >= {dm_reg, QB'(0)};
            dy_reg.zero <= zero_reg;
        end
    end

    assign div_x = dx_reg;
    assign div_y = dy_reg;

endmodule

[rtl/sgi_div_cell.sv]
module sgi_div_cell #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          en,
    input  sgi_pkg::div_t d,
    output sgi_pkg::div_t q_out
);
    import sgi_pkg::*;

    div_t             cell_reg;
    div_t             cell_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one restoring step: bring down a numerator bit, subtract if it fits
    always_comb
    begin
        trial     = {d.rem, d.num[BIT]};
        diff      = trial - {1'b0, d.dm};
        ge        = trial >= {1'b0, d.dm};
        cell_next = d;
        cell_next.rem    = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cell_next.q[BIT] = ge;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign q_out = cell_reg;

endmodule

[rtl/segment_intersection_unit.sv]
// Segment intersection unit. Takes two segments AB and CD as signed Q12.8
// endpoints and returns, one transaction per input, the line intersection
// point (truncated toward zero, clamped to the coordinate range with
// point_saturated set), a parallel flag when the direction determinant is
// zero (point then reads as zero) and a hit flag when the bounding boxes
// overlap and the point lies in both boxes widened by the tolerance
// register (reset value 1 LSB). One transaction is taken per clock while the
// output is not stalled; from input acceptance to output valid a transaction
// passes the multiply/subtract front end, a chain of 22 restoring divider cells
// (one quotient bit each, x and y in parallel) and the output register.
// A stalled output freezes the whole pipeline. Write the tolerance only
// while no transaction is in flight; cfg_ready is always high.
module segment_intersection_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sgi_pkg::seg_in_t   req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sgi_pkg::seg_out_t  rsp_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [sgi_pkg::TOL_W-1:0] cfg_tolerance
);
    import sgi_pkg::*;

    localparam int DEPTH = FRONT_STAGES + QB;

    logic                 adv;
    logic [DEPTH-1:0]     valid_reg;
    side_t                side_reg [DEPTH];
    side_t                side_in;
    logic [TOL_W-1:0]     tol_reg;
    logic                 rsp_valid_reg;
    seg_out_t             rsp_reg;
    seg_out_t             rsp_next;

    div_t                 chain_x [QB+1];
    div_t                 chain_y [QB+1];

    // whole pipe moves unless a finished result is held back
    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_W'(TOL_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_tolerance;
        end
    end

    // bounding boxes at the input
    always_comb
    begin
        side_in.l1 = (req_data.point_a_x < req_data.point_b_x) ? req_data.point_a_x
                                                               : req_data.point_b_x;
        side_in.r1 = (req_data.point_a_x > req_data.point_b_x) ? req_data.point_a_x
                                                               : req_data.point_b_x;
        side_in.t1 = (req_data.point_a_y < req_data.point_b_y) ? req_data.point_a_y
                                                               : req_data.point_b_y;
        side_in.b1 = (req_data.point_a_y > req_data.point_b_y) ? req_data.point_a_y
                                                               : req_data.point_b_y;
        side_in.l2 = (req_data.point_c_x < req_data.point_d_x) ? req_data.point_c_x
                                                               : req_data.point_d_x;
        side_in.r2 = (req_data.point_c_x > req_data.point_d_x) ? req_data.point_c_x
                                                               : req_data.point_d_x;
        side_in.t2 = (req_data.point_c_y < req_data.point_d_y) ? req_data.point_c_y
                                                               : req_data.point_d_y;
        side_in.b2 = (req_data.point_c_y > req_data.point_d_y) ? req_data.point_c_y
                                                               : req_data.point_d_y;
        side_in.overlap = (side_in.l1 <= side_in.r2) && (side_in.r1 >= side_in.l2) &&
                          (side_in.t1 <= side_in.b2) && (side_in.b1 >= side_in.t2);
    end

    // valid tokens
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[DEPTH-2:0], req_valid};
            rsp_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    // box data rides alongside the arithmetic
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    sgi_front u_front (
        .clk   (clk),
        .en    (adv),
        .seg   (req_data),
        .div_x (chain_x[0]),
        .div_y (chain_y[0])
    );

    for (genvar j = 0; j < QB; j++)
    begin : g_cell
        sgi_div_cell #(.BIT(QB - 1 - j)) u_cell_x (
            .clk   (clk),
            .en    (adv),
            .d     (chain_x[j]),
            .q_out (chain_x[j+1])
        );
        sgi_div_cell #(.BIT(QB - 1 - j)) u_cell_y (
            .clk   (clk),
            .en    (adv),
            .d     (chain_y[j]),
            .q_out (chain_y[j+1])
        );
    end

    // sign, clamp and box tests
    logic [QB-1:0]           magx, magy;
    logic signed [CMP_W-1:0] qx, qy, tol_s;
    logic                    satx, saty, in1, in2;
    side_t                   sd;

    always_comb
    begin
        sd    = side_reg[DEPTH-1];
        magx  = chain_x[QB].ovf ? '1 : chain_x[QB].q;
        magy  = chain_y[QB].ovf ? '1 : chain_y[QB].q;
        qx    = chain_x[QB].neg ? -$signed(CMP_W'(magx)) : $signed(CMP_W'(magx));
        qy    = chain_y[QB].neg ? -$signed(CMP_W'(magy)) : $signed(CMP_W'(magy));
        tol_s = $signed(CMP_W'(tol_reg));
        satx  = (qx > CMAX_C) || (qx < CMIN_C);
        saty  = (qy > CMAX_C) || (qy < CMIN_C);
        in1   = (qx <= CMP_W'(sd.r1) + tol_s) && (qx >= CMP_W'(sd.l1) - tol_s) &&
                (qy >= CMP_W'(sd.t1) - tol_s) && (qy <= CMP_W'(sd.b1) + tol_s);
        in2   = (qx <= CMP_W'(sd.r2) + tol_s) && (qx >= CMP_W'(sd.l2) - tol_s) &&
                (qy >= CMP_W'(sd.t2) - tol_s) && (qy <= CMP_W'(sd.b2) + tol_s);

        rsp_next.lines_parallel = chain_x[QB].zero;
        if (chain_x[QB].zero)
        begin
            rsp_next.segments_hit    = 1'b0;
            rsp_next.cross_x         = '0;
            rsp_next.cross_y         = '0;
            rsp_next.point_saturated = 1'b0;
        end
        else
        begin
            rsp_next.segments_hit    = sd.overlap && in1 && in2;
            rsp_next.cross_x         = (qx > CMAX_C) ? COORD_W'(CMAX_C) :
                                       (qx < CMIN_C) ? COORD_W'(CMIN_C) : COORD_W'(qx);
            rsp_next.cross_y         = (qy > CMAX_C) ? COORD_W'(CMAX_C) :
                                       (qy < CMIN_C) ? COORD_W'(CMIN_C) : COORD_W'(qy);
            rsp_next.point_saturated = satx || saty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
